### design/dgcd_pkg.sv
// dgcd_pkg: shared constants of the directed graph cycle detector
// command and status codes, field widths, default vertex count
// no dependencies
package dgcd_pkg;

    // default number of vertex slots
    localparam int VERTICES_DEF = 64;

    // field widths
    localparam int ID_W   = 31;
    localparam int FUNC_W = 2;
    localparam int STAT_W = 2;

    // command codes
    localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

endpackage

### design/directed_graph_cycle_detector_unit.sv
// directed_graph_cycle_detector_unit: top level, command sequencer
// depends on dgcd_pkg, dgcd_ram, dgcd_adj_mem
//
// One command at a time; o_stall is high from the cycle after a transfer until the
// result has been loaded into the output register. Ids are reduced mod VERTICES four
// bits per cycle by a compare-and-subtract unit, then slots are probed one at a time:
// a free slot is recognised from the used bits, an occupied one by reading its id
// through the id table's read port. A check visits each root slot in turn, scans the
// row of each visited vertex and pops back to the parent when a row is done. Results
// come back in order, one per command, held in an output register while the consumer
// stalls.
module directed_graph_cycle_detector_unit #(
    parameter int VERTICES = dgcd_pkg::VERTICES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dgcd_pkg::FUNC_W-1:0]  i_func,
    input  logic [dgcd_pkg::ID_W-1:0]    i_src_id,
    input  logic [dgcd_pkg::ID_W-1:0]    i_dst_id,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dgcd_pkg::STAT_W-1:0]  o_status,
    output logic                         o_cycle_found
);

    localparam int IW = $clog2(VERTICES);
    localparam int CW = IW + 1;
    localparam int SW = IW + CW;
    localparam int DIG_N = (dgcd_pkg::ID_W + 3) / 4;
    localparam int BW = $clog2(DIG_N);
    localparam logic [CW-1:0] V_C    = CW'(VERTICES);
    localparam logic [IW-1:0] V_LAST = IW'(VERTICES - 1);
    localparam logic [CW+3:0] V_M    = (CW+4)'(VERTICES);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MOD   = 9'b000000010,
        S_PROBE = 9'b000000100,
        S_PCMP  = 9'b000001000,
        S_ADJ   = 9'b000010000,
        S_ROOT  = 9'b000100000,
        S_SCAN  = 9'b001000000,
        S_POP   = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    logic [dgcd_pkg::ID_W-1:0]   r_id, r_dst;
    logic [BW-1:0]               r_bit;
    logic [IW-1:0]               r_rem, r_slot, r_k, r_src_slot, r_dst_slot;
    logic                        r_phase;
    logic [VERTICES-1:0]         r_used, r_grey, r_black;
    logic [CW-1:0]               r_root, r_depth, r_top_cur;
    logic [IW-1:0]               r_top_node;
    logic [dgcd_pkg::STAT_W-1:0] r_res_status, r_o_status;
    logic                        r_res_cyc, r_o_cyc, r_o_valid;

    logic                        in_xfer, out_load;
    logic [4*DIG_N-1:0]          id_pad;
    logic [3:0]                  mod_dig;
    logic [CW+3:0]               mod_t;
    logic [CW-1:0]               mod_s;
    logic [IW-1:0]               slot_nxt, cur_idx, root_idx;
    logic                        cur_end, root_end, hit, id_match, loc, root_push;
    logic [CW-1:0]               depth_m1, depth_m2;

    logic                        id_we, id_re;
    logic [dgcd_pkg::ID_W-1:0]   id_rd;
    logic                        adj_re, adj_we, adj_clr;
    logic [IW-1:0]               adj_ra;
    logic [VERTICES-1:0]         adj_row, adj_wd;
    logic                        stk_we, stk_re;
    logic [SW-1:0]               stk_wd, stk_rd;

    // handshake
    assign in_xfer  = i_valid && r_state == S_IDLE;
    assign o_stall  = r_state != S_IDLE;
    assign out_load = r_state == S_OUT && (!r_o_valid || !i_stall);
    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_cycle_found = r_o_cyc;

    // remainder step, one hex digit per cycle: rem = (16*rem + digit) mod VERTICES
    assign id_pad  = (4*DIG_N)'(r_id);
    assign mod_dig = id_pad[{r_bit, 2'b00} +: 4];

    always_comb begin
        mod_t = {1'b0, r_rem, mod_dig};
        for (int j = 3; j >= 0; j--) begin
            if (mod_t >= (V_M << j)) begin
                mod_t = mod_t - (V_M << j);
            end
        end
    end

    assign mod_s = mod_t[CW-1:0];

    // probe and walk helpers
    assign slot_nxt  = (r_slot == V_LAST) ? '0 : r_slot + 1'b1;
    assign id_match  = id_rd == r_id;
    assign loc       = (r_state == S_PROBE && !r_used[r_slot]) ||
                       (r_state == S_PCMP && id_match);
    assign cur_idx   = r_top_cur[IW-1:0];
    assign cur_end   = r_top_cur == V_C;
    assign hit       = r_used[cur_idx] && adj_row[cur_idx];
    assign root_idx  = r_root[IW-1:0];
    assign root_end  = r_root == V_C;
    assign root_push = r_used[root_idx] && !r_grey[root_idx] && !r_black[root_idx];
    assign depth_m1  = r_depth - 1'b1;
    assign depth_m2  = r_depth - 2'd2;
    assign adj_wd    = adj_row | (VERTICES'(1) << r_dst_slot);
    assign stk_wd    = {r_top_node, r_top_cur + 1'b1};

    // sequencer and memory controls
    always_comb begin
        n_state = r_state;
        id_we   = 1'b0;
        id_re   = 1'b0;
        adj_re  = 1'b0;
        adj_we  = 1'b0;
        adj_clr = 1'b0;
        adj_ra  = r_src_slot;
        stk_we  = 1'b0;
        stk_re  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    unique case (i_func)
                        dgcd_pkg::FUNC_ADD:   n_state = S_MOD;
                        dgcd_pkg::FUNC_CHECK: n_state = S_ROOT;
                        dgcd_pkg::FUNC_CLEAR: begin
                            adj_clr = 1'b1;
                            n_state = S_OUT;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_MOD: begin
                if (r_bit == '0) begin
                    n_state = S_PROBE;
                end
            end
            S_PROBE: begin
                if (!r_used[r_slot]) begin
                    id_we = 1'b1;
                end else begin
                    id_re   = 1'b1;
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                if (!id_match) begin
                    n_state = (r_k == V_LAST) ? S_OUT : S_PROBE;
                end
            end
            S_ADJ: begin
                adj_we  = !adj_row[r_dst_slot];
                n_state = S_OUT;
            end
            S_ROOT: begin
                if (root_end) begin
                    n_state = S_OUT;
                end else if (root_push) begin
                    adj_re  = 1'b1;
                    adj_ra  = root_idx;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cur_end) begin
                    if (r_depth == CW'(1)) begin
                        n_state = S_ROOT;
                    end else begin
                        stk_re  = 1'b1;
                        n_state = S_POP;
                    end
                end else if (hit) begin
                    if (r_grey[cur_idx]) begin
                        n_state = S_OUT;
                    end else if (!r_black[cur_idx]) begin
                        stk_we = 1'b1;
                        adj_re = 1'b1;
                        adj_ra = cur_idx;
                    end
                end
            end
            S_POP: begin
                adj_re  = 1'b1;
                adj_ra  = stk_rd[SW-1:CW];
                n_state = S_SCAN;
            end
            S_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // located slot: go on to the destination, or read the source row
        if (loc) begin
            if (!r_phase) begin
                n_state = S_MOD;
            end else begin
                adj_re  = 1'b1;
                n_state = S_ADJ;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_grey    <= '0;
            r_black   <= '0;
            r_depth   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            // output register
            if (out_load) begin
                r_o_valid  <= 1'b1;
                r_o_status <= r_res_status;
                r_o_cyc    <= r_res_cyc;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_res_status <= dgcd_pkg::ST_OK;
                        r_res_cyc    <= 1'b0;
                        r_id         <= i_src_id;
                        r_dst        <= i_dst_id;
                        r_phase      <= 1'b0;
                        r_rem        <= '0;
                        r_bit        <= BW'(DIG_N - 1);
                        r_root       <= '0;
                        r_depth      <= '0;
                        if (i_func == dgcd_pkg::FUNC_CHECK) begin
                            r_grey  <= '0;
                            r_black <= '0;
                        end
                        if (i_func == dgcd_pkg::FUNC_CLEAR) begin
                            r_used  <= '0;
                            r_grey  <= '0;
                            r_black <= '0;
                        end
                    end
                end
                S_MOD: begin
                    r_rem <= mod_s[IW-1:0];
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == '0) begin
                        r_slot <= mod_s[IW-1:0];
                        r_k    <= '0;
                    end
                end
                S_PROBE: begin
                    if (!r_used[r_slot]) begin
                        r_used[r_slot] <= 1'b1;
                    end
                end
                S_PCMP: begin
                    if (!id_match) begin
                        if (r_k == V_LAST) begin
                            r_res_status <= dgcd_pkg::ST_FULL;
                        end else begin
                            r_slot <= slot_nxt;
                            r_k    <= r_k + 1'b1;
                        end
                    end
                end
                S_ADJ: begin
                    if (adj_row[r_dst_slot]) begin
                        r_res_status <= dgcd_pkg::ST_PRESENT;
                    end
                end
                S_ROOT: begin
                    if (!root_end) begin
                        r_root <= r_root + 1'b1;
                        if (root_push) begin
                            r_top_node       <= root_idx;
                            r_top_cur        <= '0;
                            r_depth          <= CW'(1);
                            r_grey[root_idx] <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (cur_end) begin
                        r_black[r_top_node] <= 1'b1;
                        r_grey[r_top_node]  <= 1'b0;
                        r_depth             <= depth_m1;
                    end else if (hit && r_grey[cur_idx]) begin
                        r_res_cyc <= 1'b1;
                        r_depth   <= '0;
                    end else if (hit && !r_black[cur_idx]) begin
                        r_top_node      <= cur_idx;
                        r_top_cur       <= '0;
                        r_depth         <= r_depth + 1'b1;
                        r_grey[cur_idx] <= 1'b1;
                    end else begin
                        r_top_cur <= r_top_cur + 1'b1;
                    end
                end
                S_POP: begin
                    r_top_node <= stk_rd[SW-1:CW];
                    r_top_cur  <= stk_rd[CW-1:0];
                end
                S_OUT: begin
                end
                default: begin
                end
            endcase

            // hand over a located slot
            if (loc) begin
                if (!r_phase) begin
                    r_src_slot <= r_slot;
                    r_id       <= r_dst;
                    r_phase    <= 1'b1;
                    r_rem      <= '0;
                    r_bit      <= BW'(DIG_N - 1);
                end else begin
                    r_dst_slot <= r_slot;
                end
            end
        end
    end

    // vertex id table
    dgcd_ram #(
        .W (dgcd_pkg::ID_W),
        .D (VERTICES)
    ) u_id_ram (
        .i_clk     (i_clk),
        .i_wr_en   (id_we),
        .i_wr_addr (r_slot),
        .i_wr_data (r_id),
        .i_rd_en   (id_re),
        .i_rd_addr (r_slot),
        .o_rd_data (id_rd)
    );

    // walk stack below the top entry
    dgcd_ram #(
        .W (SW),
        .D (VERTICES)
    ) u_stack_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stk_we),
        .i_wr_addr (depth_m1[IW-1:0]),
        .i_wr_data (stk_wd),
        .i_rd_en   (stk_re),
        .i_rd_addr (depth_m2[IW-1:0]),
        .o_rd_data (stk_rd)
    );

    // adjacency matrix
    dgcd_adj_mem #(
        .V (VERTICES)
    ) u_adj_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (adj_clr),
        .i_wr_en   (adj_we),
        .i_wr_addr (r_src_slot),
        .i_wr_row  (adj_wd),
        .i_rd_en   (adj_re),
        .i_rd_addr (adj_ra),
        .o_rd_row  (adj_row)
    );

endmodule

### design/dgcd_ram.sv
// dgcd_ram: single write port, single read port memory with registered read
// used for the vertex id table and the walk stack
// no dependencies
module dgcd_ram #(
    parameter int W = 8,
    parameter int D = 64
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [$clog2(D)-1:0] i_wr_addr,
    input  logic [W-1:0]         i_wr_data,
    input  logic                 i_rd_en,
    input  logic [$clog2(D)-1:0] i_rd_addr,
    output logic [W-1:0]         o_rd_data
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_q;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

### design/dgcd_adj_mem.sv
// dgcd_adj_mem: adjacency matrix, one row per source slot
// per-row valid bits give zero rows after reset and after a graph clear
// no dependencies
module dgcd_adj_mem #(
    parameter int V = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_clr,
    input  logic                 i_wr_en,
    input  logic [$clog2(V)-1:0] i_wr_addr,
    input  logic [V-1:0]         i_wr_row,
    input  logic                 i_rd_en,
    input  logic [$clog2(V)-1:0] i_rd_addr,
    output logic [V-1:0]         o_rd_row
);

    logic [V-1:0] r_mem [V];
    logic [V-1:0] r_row_vld;
    logic [V-1:0] r_q;
    logic         r_q_vld;

    // row storage
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_row;
        end
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    // row valid bits and read qualifier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
            r_q_vld   <= 1'b0;
        end else begin
            if (i_clr) begin
                r_row_vld <= '0;
            end else if (i_wr_en) begin
                r_row_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_q_vld <= r_row_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_row = r_q_vld ? r_q : '0;

endmodule

### design/dgcd_checker.sv
// dgcd_checker: port-level assertions for the cycle detector
// depends on dgcd_pkg; bound to directed_graph_cycle_detector_unit
module dgcd_assert (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [dgcd_pkg::STAT_W-1:0] o_status,
    input logic                        o_cycle_found
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status) && $stable(o_cycle_found))
        else $error("stalled result changed");

    // one command at a time: busy right after an input transfer
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while a command is in progress");

    // status carries a defined code
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == dgcd_pkg::ST_OK || o_status == dgcd_pkg::ST_PRESENT ||
                     o_status == dgcd_pkg::ST_FULL))
        else $error("undefined status code");

    // a cycle report only comes with an ok status
    a_cycle_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_cycle_found |-> o_status == dgcd_pkg::ST_OK)
        else $error("cycle flag with non-ok status");

endmodule

bind directed_graph_cycle_detector_unit dgcd_assert u_dgcd_assert (.*);
